>>> rtl/core/stc_pkg.sv
package stc_pkg;

    localparam int SPF_DEFAULT = 80;
    localparam int IN_DATA_W   = 40;
    localparam int IN_USER_W   = 4;
    localparam int OUT_DATA_W  = 40;

    localparam logic [7:0] MAX_HOUR   = 8'd255;
    localparam logic [5:0] MAX_MIN    = 6'd59;
    localparam logic [5:0] MAX_SEC    = 6'd59;
    localparam logic [4:0] MAX_FRAME  = 5'd29;
    localparam logic [4:0] TOP_24     = 5'd23;
    localparam logic [4:0] TOP_25     = 5'd24;
    localparam logic [4:0] TOP_30     = 5'd29;
    localparam logic [4:0] DROP_FRAME = 5'd2;

    typedef enum logic [3:0] {
        OP_LOAD        = 4'd0,
        OP_FRAME_UP    = 4'd1,
        OP_FRAME_DOWN  = 4'd2,
        OP_SUB_UP      = 4'd3,
        OP_SUB_DOWN    = 4'd4,
        OP_NEXT_SEC    = 4'd5,
        OP_NEXT_MIN    = 4'd6,
        OP_NEXT_HOUR   = 4'd7,
        OP_FLOOR_FRAME = 4'd8,
        OP_FLOOR_SEC   = 4'd9,
        OP_FLOOR_MIN   = 4'd10,
        OP_FLOOR_HOUR  = 4'd11
    } op_t;

    typedef enum logic [2:0] {
        WRAP_NONE    = 3'd0,
        WRAP_FRAMES  = 3'd1,
        WRAP_SECONDS = 3'd2,
        WRAP_MINUTES = 3'd3,
        WRAP_HOURS   = 3'd4
    } wrap_t;

    typedef enum logic [1:0] {
        RATE_24      = 2'd0,
        RATE_25      = 2'd1,
        RATE_30_DROP = 2'd2,
        RATE_30      = 2'd3
    } rate_t;

    typedef struct packed {
        logic       neg;
        logic [7:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [4:0] frames;
        logic [6:0] subframes;
    } tc_t;

    typedef struct packed {
        op_t op;
        tc_t load;
    } item_t;

    typedef struct packed {
        wrap_t wrap;
        tc_t   tc;
    } result_t;

endpackage

>>> rtl/core/stc_in_reg.sv
module stc_in_reg
    import stc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  item_t item_in,
    input  logic  take,
    output logic  valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);
    assign valid      = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_in;
        end
    end

endmodule

>>> rtl/core/stc_engine.sv
module stc_engine
    import stc_pkg::*;
#(
    parameter int SUBFRAMES_PER_FRAME = SPF_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  rate_t   rate,
    output result_t result
);

    localparam logic [7:0] SPF_W  = 8'(SUBFRAMES_PER_FRAME);
    localparam logic [6:0] SF_MAX = 7'(SUBFRAMES_PER_FRAME - 1);

    tc_t tc_reg;

    function automatic logic [4:0] top_frame(input rate_t r);
        logic [4:0] v;
        case (r)
            RATE_24: v = TOP_24;
            RATE_25: v = TOP_25;
            default: v = TOP_30;
        endcase
        return v;
    endfunction

    function automatic logic tenth_min(input logic [5:0] m);
        return m inside {6'd0, 6'd10, 6'd20, 6'd30, 6'd40, 6'd50};
    endfunction

    function automatic logic tenth_next(input logic [5:0] m);
        return m inside {6'd9, 6'd19, 6'd29, 6'd39, 6'd49, 6'd59};
    endfunction

    function automatic logic mag_zero(input tc_t t);
        return t.hours == '0 && t.minutes == '0 && t.seconds == '0 && t.frames == '0;
    endfunction

    function automatic logic all_zero(input tc_t t);
        return mag_zero(t) && t.subframes == '0;
    endfunction

    function automatic tc_t clear_zero(input tc_t t);
        tc_t o;
        o = t;
        if (all_zero(t))
        begin
            o.neg = 1'b0;
        end
        return o;
    endfunction

    function automatic logic [6:0] mirror_sf(input logic [6:0] sf);
        logic [7:0] d;
        d = SPF_W - {1'b0, sf};
        return d[6:0];
    endfunction

    // magnitude one frame up
    function automatic result_t inc_frame(input tc_t t, input rate_t r);
        result_t o;
        o.tc   = t;
        o.wrap = WRAP_NONE;
        if (t.frames >= top_frame(r))
        begin
            if (r == RATE_30_DROP && !tenth_next(t.minutes) && t.seconds >= MAX_SEC)
            begin
                o.tc.frames = DROP_FRAME;
            end
            else
            begin
                o.tc.frames = '0;
            end
            if (t.seconds >= MAX_SEC)
            begin
                o.tc.seconds = '0;
                if (t.minutes >= MAX_MIN)
                begin
                    o.tc.minutes = '0;
                    o.wrap       = WRAP_HOURS;
                    if (t.hours != MAX_HOUR)
                    begin
                        o.tc.hours = t.hours + 8'd1;
                    end
                end
                else
                begin
                    o.tc.minutes = t.minutes + 6'd1;
                    o.wrap       = WRAP_MINUTES;
                end
            end
            else
            begin
                o.tc.seconds = t.seconds + 6'd1;
                o.wrap       = WRAP_SECONDS;
            end
        end
        else
        begin
            o.tc.frames = t.frames + 5'd1;
        end
        return o;
    endfunction

    // magnitude one frame down, magnitude not zero
    function automatic result_t dec_frame(input tc_t t, input rate_t r);
        result_t    o;
        logic       carry;
        logic [4:0] wrap_f;
        o.tc   = t;
        o.wrap = WRAP_NONE;
        if (r == RATE_30_DROP && !tenth_min(t.minutes) && t.seconds == '0)
        begin
            carry  = t.frames <= DROP_FRAME;
            wrap_f = MAX_FRAME;
        end
        else
        begin
            carry  = t.frames == '0;
            wrap_f = top_frame(r);
        end
        if (carry)
        begin
            o.tc.frames = wrap_f;
            if (t.seconds == '0)
            begin
                o.tc.seconds = MAX_SEC;
                if (t.minutes == '0)
                begin
                    o.tc.minutes = MAX_MIN;
                    o.wrap       = WRAP_HOURS;
                    if (t.hours != '0)
                    begin
                        o.tc.hours = t.hours - 8'd1;
                    end
                end
                else
                begin
                    o.tc.minutes = t.minutes - 6'd1;
                    o.wrap       = WRAP_MINUTES;
                end
            end
            else
            begin
                o.tc.seconds = t.seconds - 6'd1;
                o.wrap       = WRAP_SECONDS;
            end
        end
        else
        begin
            o.tc.frames = t.frames - 5'd1;
        end
        return o;
    endfunction

    function automatic result_t frame_up(input tc_t t, input rate_t r);
        result_t o;
        if (!t.neg)
        begin
            o = inc_frame(t, r);
        end
        else if (mag_zero(t) && t.subframes != '0)
        begin
            o.tc           = t;
            o.tc.subframes = mirror_sf(t.subframes);
            o.tc.neg       = 1'b0;
            o.wrap         = WRAP_SECONDS;
        end
        else if (all_zero(t))
        begin
            o        = inc_frame(t, r);
            o.tc.neg = 1'b1;
        end
        else
        begin
            o        = dec_frame(t, r);
            o.tc.neg = !all_zero(o.tc);
        end
        return o;
    endfunction

    function automatic result_t frame_down(input tc_t t, input rate_t r);
        result_t o;
        if (t.neg || all_zero(t))
        begin
            o        = inc_frame(t, r);
            o.tc.neg = 1'b1;
        end
        else if (mag_zero(t))
        begin
            o.tc           = t;
            o.tc.subframes = mirror_sf(t.subframes);
            o.tc.neg       = 1'b1;
            o.wrap         = WRAP_SECONDS;
        end
        else
        begin
            o        = dec_frame(t, r);
            o.tc.neg = 1'b0;
        end
        return o;
    endfunction

    // magnitude one subframe up
    function automatic result_t sub_inc(input tc_t t, input rate_t r);
        result_t    o;
        tc_t        z;
        logic [7:0] sum;
        sum = {1'b0, t.subframes} + 8'd1;
        if (sum >= SPF_W)
        begin
            z           = t;
            z.subframes = '0;
            o           = inc_frame(z, r);
            o.wrap      = WRAP_FRAMES;
        end
        else
        begin
            o.tc           = t;
            o.tc.subframes = sum[6:0];
            o.wrap         = WRAP_NONE;
        end
        return o;
    endfunction

    // magnitude one subframe down
    function automatic result_t sub_dec(input tc_t t, input rate_t r);
        result_t o;
        if (t.subframes == '0)
        begin
            if (all_zero(t))
            begin
                o.tc           = t;
                o.tc.neg       = 1'b1;
                o.tc.subframes = 7'd1;
            end
            else
            begin
                o              = dec_frame(t, r);
                o.tc.neg       = 1'b0;
                o.tc.subframes = SF_MAX;
            end
            o.wrap = WRAP_FRAMES;
        end
        else
        begin
            o.tc           = t;
            o.tc.subframes = t.subframes - 7'd1;
            o.tc.neg       = 1'b0;
            o.wrap         = WRAP_NONE;
        end
        return o;
    endfunction

    function automatic tc_t floor_frame(input tc_t t);
        tc_t o;
        o           = t;
        o.subframes = '0;
        return clear_zero(o);
    endfunction

    function automatic tc_t floor_second(input tc_t t, input rate_t r);
        tc_t o;
        o           = t;
        o.subframes = '0;
        if (r == RATE_30_DROP && !tenth_min(t.minutes) && t.seconds == '0)
        begin
            o.frames = DROP_FRAME;
        end
        else
        begin
            o.frames = '0;
        end
        return clear_zero(o);
    endfunction

    function automatic tc_t floor_minute(input tc_t t, input rate_t r);
        tc_t o;
        o         = t;
        o.seconds = '0;
        return floor_second(o, r);
    endfunction

    function automatic tc_t floor_hour(input tc_t t);
        tc_t o;
        o           = t;
        o.minutes   = '0;
        o.seconds   = '0;
        o.frames    = '0;
        o.subframes = '0;
        return clear_zero(o);
    endfunction

    function automatic result_t next_second(input tc_t t, input rate_t r);
        result_t o;
        tc_t     f;
        f = floor_frame(t);
        if (f.neg)
        begin
            o    = frame_up(f, r);
            o.tc = floor_second(o.tc, r);
        end
        else
        begin
            f.frames = top_frame(r);
            o        = inc_frame(f, r);
        end
        return o;
    endfunction

    function automatic result_t next_minute(input tc_t t, input rate_t r);
        result_t o;
        tc_t     f;
        f = floor_frame(t);
        if (f.neg)
        begin
            o    = next_second(f, r);
            o.tc = floor_minute(o.tc, r);
        end
        else
        begin
            f.seconds = MAX_SEC;
            o         = next_second(f, r);
        end
        return o;
    endfunction

    function automatic result_t next_hour(input tc_t t, input rate_t r);
        result_t o;
        tc_t     f;
        f = floor_frame(t);
        if (f.neg)
        begin
            o    = next_minute(f, r);
            o.tc = floor_hour(o.tc);
        end
        else
        begin
            f.minutes = MAX_MIN;
            o         = next_minute(f, r);
        end
        return o;
    endfunction

    function automatic tc_t load_time(input tc_t l);
        tc_t o;
        o.neg       = l.neg;
        o.hours     = l.hours;
        o.minutes   = (l.minutes > MAX_MIN) ? MAX_MIN : l.minutes;
        o.seconds   = (l.seconds > MAX_SEC) ? MAX_SEC : l.seconds;
        o.frames    = (l.frames > MAX_FRAME) ? MAX_FRAME : l.frames;
        o.subframes = (l.subframes > SF_MAX) ? SF_MAX : l.subframes;
        return clear_zero(o);
    endfunction

    always_comb
    begin
        result.tc   = tc_reg;
        result.wrap = WRAP_NONE;
        case (item.op)
            OP_LOAD:        result.tc = load_time(item.load);
            OP_FRAME_UP:    result = frame_up(tc_reg, rate);
            OP_FRAME_DOWN:  result = frame_down(tc_reg, rate);
            OP_SUB_UP:
            begin
                if (tc_reg.neg)
                begin
                    result        = sub_dec(tc_reg, rate);
                    result.tc.neg = !all_zero(result.tc);
                end
                else
                begin
                    result = sub_inc(tc_reg, rate);
                end
            end
            OP_SUB_DOWN:
            begin
                if (tc_reg.neg)
                begin
                    result        = sub_inc(tc_reg, rate);
                    result.tc.neg = 1'b1;
                end
                else
                begin
                    result = sub_dec(tc_reg, rate);
                end
            end
            OP_NEXT_SEC:    result = next_second(tc_reg, rate);
            OP_NEXT_MIN:    result = next_minute(tc_reg, rate);
            OP_NEXT_HOUR:   result = next_hour(tc_reg, rate);
            OP_FLOOR_FRAME: result.tc = floor_frame(tc_reg);
            OP_FLOOR_SEC:   result.tc = floor_second(tc_reg, rate);
            OP_FLOOR_MIN:   result.tc = floor_minute(tc_reg, rate);
            OP_FLOOR_HOUR:  result.tc = floor_hour(tc_reg);
            default:        result.tc = tc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg <= '0;
        end
        else if (fire)
        begin
            tc_reg <= result.tc;
        end
    end

endmodule

>>> rtl/core/stc_out_reg.sv
module stc_out_reg
    import stc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  result_t               result,
    output logic                  free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = fire || (valid_reg && !m_tready);
    assign m_tvalid   = valid_reg;
    assign m_tdata    = {4'b0,
                         result_reg.tc.subframes,
                         result_reg.tc.frames,
                         result_reg.tc.seconds,
                         result_reg.tc.minutes,
                         result_reg.tc.hours,
                         result_reg.tc.neg,
                         3'(result_reg.wrap)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

endmodule

>>> rtl/core/signed_timecode_counter.sv
// channel   dir  signals                              contents
// s_*       in   s_tvalid s_tready s_tdata s_tuser    one operation with its load time
// m_*       out  m_tvalid m_tready m_tdata            wrap level and the new time
// cfg_*     in   cfg_wr_en cfg_wr_data                frame rate register
//
// one item per cycle sustained while m_tready holds; an accepted item is registered
// in the input register, then the timecode update loads the result register,
// which drives m_tvalid
// reset: frame rate 30 fps non-drop, time +00:00:00:00.00, both stages empty
// a stalled result holds in the result register; the input register takes one
// more item behind it, then s_tready drops until m_tready returns
module signed_timecode_counter
    import stc_pkg::*;
#(
    parameter int SUBFRAMES_PER_FRAME = SPF_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // load_negative, load_hours, load_minutes, load_seconds, load_frames, load_subframes
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // operation
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // wrap_level, is_negative, hours_out, minutes_out, seconds_out, frames_out, subframes_out
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_wr_data
);

    rate_t   frame_rate_reg;
    item_t   item_in;
    item_t   item;
    logic    in_valid;
    logic    out_free;
    logic    fire;
    result_t result;

    assign item_in.op             = op_t'(s_tuser);
    assign item_in.load.neg       = s_tdata[0];
    assign item_in.load.hours     = s_tdata[8:1];
    assign item_in.load.minutes   = s_tdata[14:9];
    assign item_in.load.seconds   = s_tdata[20:15];
    assign item_in.load.frames    = s_tdata[25:21];
    assign item_in.load.subframes = s_tdata[32:26];

    assign fire = in_valid && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rate_reg <= RATE_30;
        end
        else if (cfg_wr_en)
        begin
            frame_rate_reg <= rate_t'(cfg_wr_data);
        end
    end

    stc_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .item_in  (item_in),
        .take     (fire),
        .valid    (in_valid),
        .item     (item)
    );

    stc_engine #(
        .SUBFRAMES_PER_FRAME (SUBFRAMES_PER_FRAME)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .rate   (frame_rate_reg),
        .result (result)
    );

    stc_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
